// ===== rtl/core/tbic_pkg.sv =====
// ---------------------------------------------------------------------------
// tbic_pkg
// Shared constants, status codes and single-step arithmetic helpers for the
// two-body inelastic collision pipeline.
// ---------------------------------------------------------------------------
package tbic_pkg;

   localparam int FRAC_BITS_DEF = 16;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_CLAMP = 2'd1;
   localparam logic [1:0] ST_SAME  = 2'd2;

   localparam logic [16:0] E_ONE = 17'd65536;

   typedef struct packed {
      logic [65:0] rem;
      logic [31:0] root;
   } sqrt_type;

   // one result bit of a 64-bit integer square root
   function automatic sqrt_type sqrt_step(input logic [65:0] rem, input logic [31:0] root,
                                          input int unsigned i);
      logic [65:0] trial;
      sqrt_type    res;
      trial    = ({34'b0, root} << (i + 1)) | (66'd1 << (2 * i));
      res.rem  = rem;
      res.root = root;
      if (rem >= trial) begin
         res.rem  = rem - trial;
         res.root = root | (32'd1 << i);
      end
      return res;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [71:0] x);
      if (x > 72'sd2147483647) begin
         return 32'sh7fffffff;
      end
      if (x < -72'sd2147483648) begin
         return 32'sh80000000;
      end
      return x[31:0];
   endfunction

endpackage

// ===== rtl/core/two_body_inelastic_collision_top.sv =====
// ---------------------------------------------------------------------------
// two_body_inelastic_collision_top
// Fixed-point 2D collision of two touching particles: returns both new
// velocities and a status code.
// ---------------------------------------------------------------------------
// A request is taken every cycle while the result side keeps up. The
// pipeline is built from bit-per-stage units in series: a 32-stage square
// root for the centre distance (with the mass-share divider beside it),
// FRAC_BITS+1 stages for the unit normal, a 64-stage divider for the energy
// term and a second 32-stage square root for the discriminant, plus
// multiply stages. The whole pipeline holds while a result waits at the
// output register. Status: 0 ok, 1 discriminant clamped to zero, 2
// coincident centres (velocities returned unchanged).
module two_body_inelastic_collision_top #(
   parameter int FRAC_BITS = tbic_pkg::FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_offset_x,
   input  logic [31:0] req_offset_y,
   input  logic [31:0] req_first_velocity_x,
   input  logic [31:0] req_first_velocity_y,
   input  logic [31:0] req_second_velocity_x,
   input  logic [31:0] req_second_velocity_y,
   input  logic [31:0] req_first_mass,
   input  logic [31:0] req_second_mass,
   input  logic [16:0] req_first_restitution,
   input  logic [16:0] req_second_restitution,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_new_first_x,
   output logic [31:0] rsp_new_first_y,
   output logic [31:0] rsp_new_second_x,
   output logic [31:0] rsp_new_second_y,
   output logic [1:0]  rsp_status
);
   import tbic_pkg::*;

   localparam int F      = FRAC_BITS;
   localparam int NW     = F + 2;
   localparam int S_SQ0  = 3;
   localparam int S_NSET = S_SQ0 + 32;
   localparam int S_ND0  = S_NSET + 1;
   localparam int S_NX   = S_ND0 + F + 1;
   localparam int S_PRJ  = S_NX + 1;
   localparam int S_U    = S_PRJ + 1;
   localparam int S_D    = S_U + 1;
   localparam int S_MV   = S_D + 1;
   localparam int S_VC   = S_MV + 1;
   localparam int S_A    = S_VC + 1;
   localparam int S_AV2  = S_A + 1;
   localparam int S_QP   = S_AV2 + 1;
   localparam int S_Q    = S_QP + 1;
   localparam int S_TSET = S_Q + 1;
   localparam int S_TD0  = S_TSET + 1;
   localparam int S_CMP  = S_TD0 + 64;
   localparam int S_RS0  = S_CMP + 1;
   localparam int S_SW   = S_RS0 + 32;
   localparam int S_N    = S_SW + 1;
   localparam int S_DD   = S_N + 1;
   localparam int S_FP   = S_DD + 1;
   localparam int LAST   = S_FP + 1;

   localparam logic [F:0] ONE_N = {1'b1, {F{1'b0}}};

   typedef struct packed {
      logic signed [31:0]     ox, oy, v1x, v1y, v2x, v2y;
      logic [31:0]            m1, m2;
      logic [16:0]            e1, e2;
      logic [32:0]            msum, r;
      logic [63:0]            sqx, sqy;
      logic                   zero;
      logic [65:0]            s_rem;
      logic [31:0]            s_root;
      logic [33:0]            w_rem;
      logic [31:0]            w1;
      logic [32:0]            w2;
      logic [64:0]            wp;
      logic [31:0]            len, ax, ay;
      logic                   sx, sy;
      logic [32:0]            nx_rem, ny_rem;
      logic [F:0]             nx_q, ny_q;
      logic signed [NW-1:0]   nx, ny;
      logic signed [NW+31:0]  px1, py1, px2, py2;
      logic signed [31:0]     u1, u2;
      logic                   dneg;
      logic [32:0]            ad;
      logic [64:0]            mvp;
      logic [65:0]            adsq;
      logic signed [33:0]     vc;
      logic [64:0]            ah, al;
      logic [63:0]            big_a;
      logic [31:0]            av;
      logic [63:0]            avsq;
      logic [64:0]            qh, ql;
      logic [63:0]            q;
      logic                   tsat;
      logic [31:0]            t_rem;
      logic [63:0]            t_q;
      logic [1:0]             status;
      logic [64:0]            sw1, sw2;
      logic signed [35:0]     n1, n2, dd1, dd2;
      logic signed [NW+35:0]  f1x, f1y, f2x, f2y;
      logic signed [31:0]     o1x, o1y, o2x, o2y;
   } item_type;

   item_type        pipe_ff [0:LAST];
   item_type        pipe_in [0:LAST];
   logic [LAST:0]   valid_ff;
   logic            en;

   assign en        = !valid_ff[LAST] || rsp_ready;
   assign req_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[LAST-1:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k <= LAST; k++) begin
            pipe_ff[k] <= pipe_in[k];
         end
      end
   end

   // capture and clamp
   always_comb begin
      pipe_in[0]        = '0;
      pipe_in[0].ox     = req_offset_x;
      pipe_in[0].oy     = req_offset_y;
      pipe_in[0].v1x    = req_first_velocity_x;
      pipe_in[0].v1y    = req_first_velocity_y;
      pipe_in[0].v2x    = req_second_velocity_x;
      pipe_in[0].v2y    = req_second_velocity_y;
      pipe_in[0].m1     = (req_first_mass == '0) ? 32'd1 : req_first_mass;
      pipe_in[0].m2     = (req_second_mass == '0) ? 32'd1 : req_second_mass;
      pipe_in[0].e1     = (req_first_restitution > E_ONE) ? E_ONE : req_first_restitution;
      pipe_in[0].e2     = (req_second_restitution > E_ONE) ? E_ONE : req_second_restitution;
      pipe_in[0].status = ST_OK;
   end

   // squares, mass sum, restitution product
   always_comb begin
      logic signed [63:0] tx, ty;
      pipe_in[1]      = pipe_ff[0];
      tx              = $signed(pipe_ff[0].ox) * $signed(pipe_ff[0].ox);
      ty              = $signed(pipe_ff[0].oy) * $signed(pipe_ff[0].oy);
      pipe_in[1].sqx  = $unsigned(tx);
      pipe_in[1].sqy  = $unsigned(ty);
      pipe_in[1].msum = {1'b0, pipe_ff[0].m1} + {1'b0, pipe_ff[0].m2};
      pipe_in[1].r    = 33'(pipe_ff[0].e1) * 33'(pipe_ff[0].e2);
   end

   always_comb begin
      logic [63:0] len2;
      pipe_in[2]        = pipe_ff[1];
      len2              = pipe_ff[1].sqx + pipe_ff[1].sqy;
      pipe_in[2].zero   = (len2 == '0);
      pipe_in[2].s_rem  = {2'b0, len2};
      pipe_in[2].s_root = '0;
      pipe_in[2].w_rem  = {2'b0, pipe_ff[1].m1};
      pipe_in[2].w1     = '0;
   end

   // distance square root beside mass-share divide
   for (genvar j = 0; j < 32; j++) begin : g_len
      localparam int K = S_SQ0 + j;
      always_comb begin
         sqrt_type    st;
         logic [33:0] rr;
         pipe_in[K]        = pipe_ff[K-1];
         st                = sqrt_step(pipe_ff[K-1].s_rem, pipe_ff[K-1].s_root, 31 - j);
         pipe_in[K].s_rem  = st.rem;
         pipe_in[K].s_root = st.root;
         rr                = {pipe_ff[K-1].w_rem[32:0], 1'b0};
         if (rr >= {1'b0, pipe_ff[K-1].msum}) begin
            pipe_in[K].w_rem     = rr - {1'b0, pipe_ff[K-1].msum};
            pipe_in[K].w1[31-j]  = 1'b1;
         end else begin
            pipe_in[K].w_rem     = rr;
         end
      end
   end

   always_comb begin
      pipe_in[S_NSET]        = pipe_ff[S_NSET-1];
      pipe_in[S_NSET].len    = pipe_ff[S_NSET-1].s_root;
      pipe_in[S_NSET].sx     = pipe_ff[S_NSET-1].ox[31];
      pipe_in[S_NSET].sy     = pipe_ff[S_NSET-1].oy[31];
      pipe_in[S_NSET].ax     = pipe_ff[S_NSET-1].ox[31] ? 32'(-pipe_ff[S_NSET-1].ox)
                                                        : 32'(pipe_ff[S_NSET-1].ox);
      pipe_in[S_NSET].ay     = pipe_ff[S_NSET-1].oy[31] ? 32'(-pipe_ff[S_NSET-1].oy)
                                                        : 32'(pipe_ff[S_NSET-1].oy);
      pipe_in[S_NSET].nx_rem = '0;
      pipe_in[S_NSET].ny_rem = '0;
      pipe_in[S_NSET].nx_q   = '0;
      pipe_in[S_NSET].ny_q   = '0;
      pipe_in[S_NSET].w2     = 33'h1_0000_0000 - {1'b0, pipe_ff[S_NSET-1].w1};
      pipe_in[S_NSET].wp     = 65'(pipe_ff[S_NSET-1].w1)
                               * 65'(33'h1_0000_0000 - {1'b0, pipe_ff[S_NSET-1].w1});
   end

   // unit normal: |offset| * 2^F / len, one quotient bit per stage
   for (genvar j = 0; j <= F; j++) begin : g_norm
      localparam int K = S_ND0 + j;
      always_comb begin
         logic [32:0] rx, ry, dl;
         pipe_in[K] = pipe_ff[K-1];
         dl         = {1'b0, pipe_ff[K-1].len};
         if (j == 0) begin
            rx = {1'b0, pipe_ff[K-1].ax};
            ry = {1'b0, pipe_ff[K-1].ay};
         end else begin
            rx = {pipe_ff[K-1].nx_rem[31:0], 1'b0};
            ry = {pipe_ff[K-1].ny_rem[31:0], 1'b0};
         end
         pipe_in[K].nx_rem = rx;
         pipe_in[K].ny_rem = ry;
         if (rx >= dl) begin
            pipe_in[K].nx_rem     = rx - dl;
            pipe_in[K].nx_q[F-j]  = 1'b1;
         end
         if (ry >= dl) begin
            pipe_in[K].ny_rem     = ry - dl;
            pipe_in[K].ny_q[F-j]  = 1'b1;
         end
      end
   end

   always_comb begin
      pipe_in[S_NX]    = pipe_ff[S_NX-1];
      pipe_in[S_NX].nx = pipe_ff[S_NX-1].sx ? -$signed({1'b0, pipe_ff[S_NX-1].nx_q})
                                            :  $signed({1'b0, pipe_ff[S_NX-1].nx_q});
      pipe_in[S_NX].ny = pipe_ff[S_NX-1].sy ? -$signed({1'b0, pipe_ff[S_NX-1].ny_q})
                                            :  $signed({1'b0, pipe_ff[S_NX-1].ny_q});
   end

   always_comb begin
      pipe_in[S_PRJ]     = pipe_ff[S_PRJ-1];
      pipe_in[S_PRJ].px1 = $signed(pipe_ff[S_PRJ-1].nx) * $signed(pipe_ff[S_PRJ-1].v1x);
      pipe_in[S_PRJ].py1 = $signed(pipe_ff[S_PRJ-1].ny) * $signed(pipe_ff[S_PRJ-1].v1y);
      pipe_in[S_PRJ].px2 = $signed(pipe_ff[S_PRJ-1].nx) * $signed(pipe_ff[S_PRJ-1].v2x);
      pipe_in[S_PRJ].py2 = $signed(pipe_ff[S_PRJ-1].ny) * $signed(pipe_ff[S_PRJ-1].v2y);
   end

   always_comb begin
      logic signed [NW+32:0] s1, s2;
      pipe_in[S_U]    = pipe_ff[S_U-1];
      s1              = $signed(pipe_ff[S_U-1].px1) + $signed(pipe_ff[S_U-1].py1);
      s2              = $signed(pipe_ff[S_U-1].px2) + $signed(pipe_ff[S_U-1].py2);
      pipe_in[S_U].u1 = sat32(72'(s1 >>> F));
      pipe_in[S_U].u2 = sat32(72'(s2 >>> F));
   end

   always_comb begin
      logic signed [32:0] dd;
      pipe_in[S_D]      = pipe_ff[S_D-1];
      dd                = $signed({pipe_ff[S_D-1].u1[31], pipe_ff[S_D-1].u1})
                          - $signed({pipe_ff[S_D-1].u2[31], pipe_ff[S_D-1].u2});
      pipe_in[S_D].dneg = dd[32];
      pipe_in[S_D].ad   = dd[32] ? 33'(-dd) : 33'(dd);
   end

   always_comb begin
      pipe_in[S_MV]      = pipe_ff[S_MV-1];
      pipe_in[S_MV].mvp  = 65'(pipe_ff[S_MV-1].ad) * 65'(pipe_ff[S_MV-1].w1);
      pipe_in[S_MV].adsq = 66'(pipe_ff[S_MV-1].ad) * 66'(pipe_ff[S_MV-1].ad);
   end

   // centre-of-mass speed; partial products of d^2 * r
   always_comb begin
      logic [32:0] mv;
      pipe_in[S_VC]    = pipe_ff[S_VC-1];
      mv               = pipe_ff[S_VC-1].mvp[64:32];
      pipe_in[S_VC].vc = pipe_ff[S_VC-1].dneg
                         ? 34'($signed(pipe_ff[S_VC-1].u2)) - $signed({1'b0, mv})
                         : 34'($signed(pipe_ff[S_VC-1].u2)) + $signed({1'b0, mv});
      pipe_in[S_VC].ah = 65'(pipe_ff[S_VC-1].adsq[63:32]) * 65'(pipe_ff[S_VC-1].r);
      pipe_in[S_VC].al = 65'(pipe_ff[S_VC-1].adsq[31:0]) * 65'(pipe_ff[S_VC-1].r);
   end

   always_comb begin
      pipe_in[S_A]       = pipe_ff[S_A-1];
      pipe_in[S_A].big_a = pipe_ff[S_A-1].ah[63:0] + 64'(pipe_ff[S_A-1].al[64:32]);
      pipe_in[S_A].av    = pipe_ff[S_A-1].vc[33] ? 32'(-pipe_ff[S_A-1].vc)
                                                 : 32'(pipe_ff[S_A-1].vc);
   end

   always_comb begin
      pipe_in[S_AV2]      = pipe_ff[S_AV2-1];
      pipe_in[S_AV2].avsq = 64'(pipe_ff[S_AV2-1].av) * 64'(pipe_ff[S_AV2-1].av);
   end

   always_comb begin
      logic [32:0] rc;
      pipe_in[S_QP]    = pipe_ff[S_QP-1];
      rc               = 33'h1_0000_0000 - pipe_ff[S_QP-1].r;
      pipe_in[S_QP].qh = 65'(pipe_ff[S_QP-1].avsq[63:32]) * 65'(rc);
      pipe_in[S_QP].ql = 65'(pipe_ff[S_QP-1].avsq[31:0]) * 65'(rc);
   end

   always_comb begin
      pipe_in[S_Q]   = pipe_ff[S_Q-1];
      pipe_in[S_Q].q = pipe_ff[S_Q-1].qh[63:0] + 64'(pipe_ff[S_Q-1].ql[64:32]);
   end

   // energy term q * 2^32 / p: saturate check, then 64 quotient bits
   always_comb begin
      logic [30:0] pv;
      pipe_in[S_TSET]       = pipe_ff[S_TSET-1];
      pv                    = pipe_ff[S_TSET-1].wp[62:32];
      pipe_in[S_TSET].tsat  = (pipe_ff[S_TSET-1].q != '0)
                              && (pipe_ff[S_TSET-1].q >= {1'b0, pv, 32'b0});
      pipe_in[S_TSET].t_rem = pipe_ff[S_TSET-1].q[63:32];
      pipe_in[S_TSET].t_q   = '0;
   end

   for (genvar j = 0; j < 64; j++) begin : g_tdiv
      localparam int K = S_TD0 + j;
      always_comb begin
         logic [32:0] rt, dv;
         logic        inb;
         pipe_in[K] = pipe_ff[K-1];
         dv         = {2'b0, pipe_ff[K-1].wp[62:32]};
         if (j < 32) begin
            inb = pipe_ff[K-1].q[31-j];
         end else begin
            inb = 1'b0;
         end
         rt = {pipe_ff[K-1].t_rem, inb};
         if (rt >= dv) begin
            rt                   = rt - dv;
            pipe_in[K].t_q[63-j] = 1'b1;
         end
         pipe_in[K].t_rem = rt[31:0];
      end
   end

   // zero energy term gives zero, even with a zero mass-share product
   always_comb begin
      logic [63:0] t;
      pipe_in[S_CMP]        = pipe_ff[S_CMP-1];
      t                     = pipe_ff[S_CMP-1].tsat ? '1 : pipe_ff[S_CMP-1].t_q;
      if (pipe_ff[S_CMP-1].q == '0) begin
         t = '0;
      end
      pipe_in[S_CMP].s_root = '0;
      if (t > pipe_ff[S_CMP-1].big_a) begin
         pipe_in[S_CMP].status = ST_CLAMP;
         pipe_in[S_CMP].s_rem  = '0;
      end else begin
         pipe_in[S_CMP].s_rem  = {2'b0, pipe_ff[S_CMP-1].big_a - t};
      end
   end

   // discriminant square root
   for (genvar j = 0; j < 32; j++) begin : g_root
      localparam int K = S_RS0 + j;
      always_comb begin
         sqrt_type st;
         pipe_in[K]        = pipe_ff[K-1];
         st                = sqrt_step(pipe_ff[K-1].s_rem, pipe_ff[K-1].s_root, 31 - j);
         pipe_in[K].s_rem  = st.rem;
         pipe_in[K].s_root = st.root;
      end
   end

   always_comb begin
      pipe_in[S_SW]     = pipe_ff[S_SW-1];
      pipe_in[S_SW].sw2 = 65'(pipe_ff[S_SW-1].s_root) * 65'(pipe_ff[S_SW-1].w2);
      pipe_in[S_SW].sw1 = 65'(pipe_ff[S_SW-1].s_root) * 65'(pipe_ff[S_SW-1].w1);
   end

   always_comb begin
      pipe_in[S_N]    = pipe_ff[S_N-1];
      pipe_in[S_N].n1 = 36'($signed(pipe_ff[S_N-1].vc))
                        + $signed({3'b0, pipe_ff[S_N-1].sw2[64:32]});
      pipe_in[S_N].n2 = 36'($signed(pipe_ff[S_N-1].vc))
                        - $signed({3'b0, pipe_ff[S_N-1].sw1[64:32]});
   end

   always_comb begin
      pipe_in[S_DD]     = pipe_ff[S_DD-1];
      pipe_in[S_DD].dd1 = $signed(pipe_ff[S_DD-1].n1) - 36'($signed(pipe_ff[S_DD-1].u1));
      pipe_in[S_DD].dd2 = $signed(pipe_ff[S_DD-1].n2) - 36'($signed(pipe_ff[S_DD-1].u2));
   end

   always_comb begin
      pipe_in[S_FP]     = pipe_ff[S_FP-1];
      pipe_in[S_FP].f1x = $signed(pipe_ff[S_FP-1].nx) * $signed(pipe_ff[S_FP-1].dd1);
      pipe_in[S_FP].f1y = $signed(pipe_ff[S_FP-1].ny) * $signed(pipe_ff[S_FP-1].dd1);
      pipe_in[S_FP].f2x = $signed(pipe_ff[S_FP-1].nx) * $signed(pipe_ff[S_FP-1].dd2);
      pipe_in[S_FP].f2y = $signed(pipe_ff[S_FP-1].ny) * $signed(pipe_ff[S_FP-1].dd2);
   end

   // output register
   always_comb begin
      pipe_in[LAST] = pipe_ff[LAST-1];
      if (pipe_ff[LAST-1].zero) begin
         pipe_in[LAST].o1x    = pipe_ff[LAST-1].v1x;
         pipe_in[LAST].o1y    = pipe_ff[LAST-1].v1y;
         pipe_in[LAST].o2x    = pipe_ff[LAST-1].v2x;
         pipe_in[LAST].o2y    = pipe_ff[LAST-1].v2y;
         pipe_in[LAST].status = ST_SAME;
      end else begin
         pipe_in[LAST].o1x = sat32(72'($signed(pipe_ff[LAST-1].v1x))
                                   + 72'($signed(pipe_ff[LAST-1].f1x) >>> F));
         pipe_in[LAST].o1y = sat32(72'($signed(pipe_ff[LAST-1].v1y))
                                   + 72'($signed(pipe_ff[LAST-1].f1y) >>> F));
         pipe_in[LAST].o2x = sat32(72'($signed(pipe_ff[LAST-1].v2x))
                                   + 72'($signed(pipe_ff[LAST-1].f2x) >>> F));
         pipe_in[LAST].o2y = sat32(72'($signed(pipe_ff[LAST-1].v2y))
                                   + 72'($signed(pipe_ff[LAST-1].f2y) >>> F));
      end
   end

   assign rsp_valid        = valid_ff[LAST];
   assign rsp_new_first_x  = pipe_ff[LAST].o1x;
   assign rsp_new_first_y  = pipe_ff[LAST].o1y;
   assign rsp_new_second_x = pipe_ff[LAST].o2x;
   assign rsp_new_second_y = pipe_ff[LAST].o2y;
   assign rsp_status       = pipe_ff[LAST].status;

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(valid_ff))
      else $error("pipeline moved during stall");

   a_root_floor: assert property (@(posedge clock) disable iff (reset)
      valid_ff[S_NSET-1] |->
         pipe_ff[S_NSET-1].s_rem <= {33'b0, pipe_ff[S_NSET-1].s_root, 1'b0})
      else $error("distance root not floor sqrt");

   a_norm_bound: assert property (@(posedge clock) disable iff (reset)
      valid_ff[S_NX-1] && !pipe_ff[S_NX-1].zero |->
         pipe_ff[S_NX-1].nx_q <= ONE_N && pipe_ff[S_NX-1].ny_q <= ONE_N)
      else $error("normal component above one");

endmodule

// ===== test/two_body_inelastic_collision_checker.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// two_body_inelastic_collision_checker
// Watches the request and response channels of the collision pipeline. For
// every accepted request it computes the expected new velocities and status
// in fixed point, queues them, and compares each accepted response field by
// field against the oldest entry.
// ---------------------------------------------------------------------------
module two_body_inelastic_collision_checker #(
   parameter int FRAC_BITS = tbic_pkg::FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [31:0] req_offset_x,
   input  logic [31:0] req_offset_y,
   input  logic [31:0] req_first_velocity_x,
   input  logic [31:0] req_first_velocity_y,
   input  logic [31:0] req_second_velocity_x,
   input  logic [31:0] req_second_velocity_y,
   input  logic [31:0] req_first_mass,
   input  logic [31:0] req_second_mass,
   input  logic [16:0] req_first_restitution,
   input  logic [16:0] req_second_restitution,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [31:0] rsp_new_first_x,
   input  logic [31:0] rsp_new_first_y,
   input  logic [31:0] rsp_new_second_x,
   input  logic [31:0] rsp_new_second_y,
   input  logic [1:0]  rsp_status,
   output int          errors,
   output int          pending
);
   import tbic_pkg::*;

   typedef struct {
      logic [31:0] fx;
      logic [31:0] fy;
      logic [31:0] sx;
      logic [31:0] sy;
      logic [1:0]  status;
   } velocities_type;

   velocities_type expected_velocities[$];

   function automatic longint unsigned isqrt(longint unsigned x);
      longint unsigned res, b;
      res = 0;
      b   = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= res + b) begin
            x   = x - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   function automatic longint unsigned scale_q32(longint unsigned a, longint unsigned f);
      return (a >> 32) * f + (((a & 64'hffffffff) * f) >> 32);
   endfunction

   function automatic longint clip32(longint x);
      if (x > 64'sh7fffffff) return 64'sh7fffffff;
      if (x < -64'sh80000000) return -64'sh80000000;
      return x;
   endfunction

   function automatic longint unsigned absval(longint x);
      return x < 0 ? longint'(-x) : x;
   endfunction

   function automatic velocities_type collide(
      logic [31:0] ox_b, logic [31:0] oy_b, logic [31:0] v1x_b, logic [31:0] v1y_b,
      logic [31:0] v2x_b, logic [31:0] v2y_b, logic [31:0] m1_b, logic [31:0] m2_b,
      logic [16:0] e1_b, logic [16:0] e2_b);
      longint ox, oy, v1x, v1y, v2x, v2y, nx, ny, u1, u2, d, vc, n1, n2, d1, d2;
      longint unsigned m1, m2, e1, e2, len2, len, w1, w2, r, ad, mv, big_a, av, q, p, t, s;
      velocities_type res;
      ox  = longint'(signed'(ox_b));
      oy  = longint'(signed'(oy_b));
      v1x = longint'(signed'(v1x_b));
      v1y = longint'(signed'(v1y_b));
      v2x = longint'(signed'(v2x_b));
      v2y = longint'(signed'(v2y_b));
      m1  = 64'((m1_b == '0) ? 32'd1 : m1_b);
      m2  = 64'((m2_b == '0) ? 32'd1 : m2_b);
      e1  = 64'((e1_b > E_ONE) ? E_ONE : e1_b);
      e2  = 64'((e2_b > E_ONE) ? E_ONE : e2_b);
      res.status = ST_OK;
      len2 = longint'(ox * ox) + longint'(oy * oy);
      if (len2 == 0) begin
         res.fx = v1x_b;
         res.fy = v1y_b;
         res.sx = v2x_b;
         res.sy = v2y_b;
         res.status = ST_SAME;
         return res;
      end
      len = isqrt(len2);
      nx  = longint'((absval(ox) << FRAC_BITS) / len);
      ny  = longint'((absval(oy) << FRAC_BITS) / len);
      if (ox < 0) nx = -nx;
      if (oy < 0) ny = -ny;
      u1 = clip32((nx * v1x + ny * v1y) >>> FRAC_BITS);
      u2 = clip32((nx * v2x + ny * v2y) >>> FRAC_BITS);
      d  = u1 - u2;
      ad = absval(d);
      w1 = (m1 << 32) / (m1 + m2);
      w2 = (64'd1 << 32) - w1;
      r  = e1 * e2;
      mv = scale_q32(ad, w1);
      vc = (d < 0) ? u2 - longint'(mv) : u2 + longint'(mv);
      big_a = scale_q32(ad * ad, r);
      av = absval(vc);
      q  = scale_q32(av * av, (64'd1 << 32) - r);
      p  = (w1 * w2) >> 32;
      if (q == 0) t = 0;
      else if (p == 0 || q / p >= (64'd1 << 32)) t = '1;
      else t = ((q / p) << 32) + (((q % p) << 32) / p);
      if (t > big_a) begin
         res.status = ST_CLAMP;
         s = 0;
      end else begin
         s = isqrt(big_a - t);
      end
      n1 = vc + longint'(scale_q32(s, w2));
      n2 = vc - longint'(scale_q32(s, w1));
      d1 = n1 - u1;
      d2 = n2 - u2;
      res.fx = 32'(clip32(v1x + ((nx * d1) >>> FRAC_BITS)));
      res.fy = 32'(clip32(v1y + ((ny * d1) >>> FRAC_BITS)));
      res.sx = 32'(clip32(v2x + ((nx * d2) >>> FRAC_BITS)));
      res.sy = 32'(clip32(v2y + ((ny * d2) >>> FRAC_BITS)));
      return res;
   endfunction

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
      errors++;
   endtask

   initial errors = 0;

   always @(posedge clock) begin
      velocities_type e;
      if (!reset && req_valid && req_ready) begin
         expected_velocities.push_back(collide(req_offset_x, req_offset_y,
            req_first_velocity_x, req_first_velocity_y, req_second_velocity_x,
            req_second_velocity_y, req_first_mass, req_second_mass,
            req_first_restitution, req_second_restitution));
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_velocities.size() == 0) begin
            report("unexpected response", '0, '0);
         end else begin
            e = expected_velocities.pop_front();
            if (rsp_new_first_x !== e.fx) report("new_first_x", rsp_new_first_x, e.fx);
            if (rsp_new_first_y !== e.fy) report("new_first_y", rsp_new_first_y, e.fy);
            if (rsp_new_second_x !== e.sx) report("new_second_x", rsp_new_second_x, e.sx);
            if (rsp_new_second_y !== e.sy) report("new_second_y", rsp_new_second_y, e.sy);
            if (rsp_status !== e.status) begin
               report("status", 32'(rsp_status), 32'(e.status));
            end
         end
      end
      pending = expected_velocities.size();
   end

endmodule

// ===== test/two_body_inelastic_collision_top_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// two_body_inelastic_collision_top_tb
// Drives directed and random collision requests with bursty input and a
// stalling response side; the checker predicts and compares every response.
// ---------------------------------------------------------------------------
module two_body_inelastic_collision_top_tb;
   import tbic_pkg::*;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic [31:0] ox = 0, oy = 0, v1x = 0, v1y = 0, v2x = 0, v2y = 0, m1 = 1, m2 = 1;
   logic [16:0] e1 = 0, e2 = 0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [31:0] nfx, nfy, nsx, nsy;
   logic [1:0]  status;
   int          errors, pending;
   int          burst_left = 0;
   int          stall_mode = 0;

   always #5 clock = ~clock;

   two_body_inelastic_collision_top u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_offset_x(ox), .req_offset_y(oy),
      .req_first_velocity_x(v1x), .req_first_velocity_y(v1y),
      .req_second_velocity_x(v2x), .req_second_velocity_y(v2y),
      .req_first_mass(m1), .req_second_mass(m2),
      .req_first_restitution(e1), .req_second_restitution(e2),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_new_first_x(nfx), .rsp_new_first_y(nfy),
      .rsp_new_second_x(nsx), .rsp_new_second_y(nsy), .rsp_status(status)
   );

   two_body_inelastic_collision_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_offset_x(ox), .req_offset_y(oy),
      .req_first_velocity_x(v1x), .req_first_velocity_y(v1y),
      .req_second_velocity_x(v2x), .req_second_velocity_y(v2y),
      .req_first_mass(m1), .req_second_mass(m2),
      .req_first_restitution(e1), .req_second_restitution(e2),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_new_first_x(nfx), .rsp_new_first_y(nfy),
      .rsp_new_second_x(nsx), .rsp_new_second_y(nsy), .rsp_status(status),
      .errors(errors), .pending(pending)
   );

   // response stalls: phases of always-ready, random, and heavy back-pressure
   always @(posedge clock) begin
      if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= 1'($urandom_range(0, 1));
         default: rsp_ready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   task automatic send_request(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                               logic [31:0] d, logic [31:0] e, logic [31:0] f,
                               logic [31:0] g, logic [31:0] h, logic [16:0] i,
                               logic [16:0] j);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_valid <= 1'b1;
      ox <= a; oy <= b; v1x <= c; v1y <= d; v2x <= e; v2y <= f;
      m1 <= g; m2 <= h; e1 <= i; e2 <= j;
      do @(posedge clock); while (!req_ready);
   endtask

   function automatic logic [31:0] rand_field(int mode);
      logic [31:0] x;
      case (mode)
         0: x = $urandom;
         1: x = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
         2: x = $urandom_range(0, 32'h0000_0400) - 32'h0000_0200;
         default: x = $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      endcase
      return x;
   endfunction

   function automatic logic [16:0] rand_rest();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return E_ONE;
         2: return 17'($urandom_range(0, 17'h1ffff));
         default: return 17'($urandom_range(0, E_ONE));
      endcase
   endfunction

   function automatic logic [31:0] rand_mass();
      case ($urandom_range(0, 9))
         0: return $urandom_range(0, 2);
         1: return 32'hffffffff;
         2: return $urandom;
         default: return $urandom_range(32'h0000_1000, 32'h0010_0000);
      endcase
   endfunction

   initial begin
      int mode;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // coincident centres
      send_request(0, 0, 32'h0001_0000, 32'hffff_0000, 32'h7fffffff, 32'h80000000,
                   32'h10000, 32'h10000, E_ONE, E_ONE);
      // head-on, equal masses, elastic and fully plastic; then oblique, unequal masses
      send_request(32'h10000, 0, 32'hffff_0000, 0, 32'h0001_0000, 0,
                   32'h10000, 32'h10000, E_ONE, E_ONE);
      send_request(32'h10000, 0, 32'hffff_0000, 0, 32'h0001_0000, 0,
                   32'h10000, 32'h10000, 0, 0);
      send_request(32'h10000, 32'h10000, 32'hfffe_0000, 32'h0003_0000, 32'h0001_0000,
                   32'hffff_8000, 32'h30000, 32'h10000, 32'h8000, E_ONE);
      // zero and extreme masses, restitution above one
      send_request(32'hfff0_0000, 32'h0008_0000, 32'h5000, 32'h3000, 32'hffff_1000, 0,
                   0, 0, 17'h1ffff, 17'h10001);
      send_request(32'h3, 32'hfffffffd, 32'h20000, 0, 0, 32'h20000,
                   32'hffffffff, 32'h1, E_ONE, 17'h1ffff);
      send_request(32'h1, 0, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
                   32'h1, 32'hffffffff, E_ONE, E_ONE);
      // extreme offsets and velocities, saturation of normal speeds
      send_request(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
                   32'h80000000, 32'h80000000, 32'hffffffff, 32'hffffffff, E_ONE, E_ONE);
      send_request(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                   32'h7fffffff, 32'h80000000, 32'h10000, 32'h10000, 0, E_ONE);
      send_request(32'h80000000, 0, 32'h7fffffff, 0, 32'h80000000, 0,
                   32'h10000, 32'h10000, E_ONE, E_ONE);
      send_request(0, 32'hffffffff, 32'h0, 32'hffffffff, 32'h0, 32'h1,
                   32'h1, 32'h1, 32'h8000, 32'h8000);
      send_request(0, 32'h10000, 0, 32'h10000, 0, 32'hffff0000,
                   32'h10000, 32'h20000, 17'h1, 17'h1);
      // separating particles: negative discriminant at low restitution
      send_request(32'h10000, 0, 32'h50000, 0, 32'h10000, 0,
                   32'h10000, 32'h10000, 32'h4000, 32'h4000);
      for (int k = 0; k < 1300; k++) begin
         if (k == 650) begin
            req_valid <= 1'b0;
            burst_left = 0;
            @(posedge clock);
            while (pending != 0) @(posedge clock);
         end
         mode = $urandom_range(0, 9);
         if (mode < 2) begin
            send_request(rand_field(0), rand_field(0), rand_field(0), rand_field(0),
                         rand_field(0), rand_field(0), $urandom, $urandom,
                         17'($urandom_range(0, 17'h1ffff)),
                         17'($urandom_range(0, 17'h1ffff)));
         end else if (mode == 2) begin
            send_request(rand_field(3), rand_field($urandom_range(0, 3)), rand_field(3),
                         rand_field(3), rand_field(3), rand_field(0), rand_mass(),
                         rand_mass(), rand_rest(), rand_rest());
         end else if (mode == 3) begin
            send_request($urandom_range(0, 7) == 0 ? 0 : rand_field(2),
                         $urandom_range(0, 7) == 0 ? 0 : rand_field(2),
                         rand_field(1), rand_field(1), rand_field(1), rand_field(1),
                         rand_mass(), rand_mass(), rand_rest(), rand_rest());
         end else begin
            send_request(rand_field(1), rand_field(1), rand_field(1), rand_field(1),
                         rand_field(1), rand_field(1), rand_mass(), rand_mass(),
                         rand_rest(), rand_rest());
         end
      end
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (errors == 0) begin
         $display("PASS two_body_inelastic_collision_top");
      end else begin
         $display("FAIL two_body_inelastic_collision_top");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("FAIL two_body_inelastic_collision_top");
      $finish;
   end

endmodule
